[rtl/f2d_pkg.sv]
// shared types, constants and helpers of the float to decimal text block
`default_nettype none
package f2d_pkg;

    localparam int MAX_PREC = 9;

    // datapath widths
    localparam int SIG_W  = 24;
    localparam int SCL_W  = 30;
    localparam int NUM_W  = SIG_W + SCL_W;
    localparam int TOT_W  = 62;
    localparam int IPR_W  = 32;
    localparam int INT_W  = 33;
    localparam int DIG_W  = 34;
    localparam int SH_W   = 8;

    // exponent field landmarks
    localparam logic [7:0] EXP_SPECIAL = 8'hFF;
    localparam logic [7:0] EXP_LIMIT   = 8'd159;
    localparam logic [7:0] EXP_UNIT    = 8'd150;
    localparam logic [7:0] SUB_SHIFT   = 8'd149;

    // characters
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_NUL  = 8'h00;

    localparam logic [SCL_W-1:0] POW10 [0:9] = '{
        30'd1, 30'd10, 30'd100, 30'd1000, 30'd10000, 30'd100000,
        30'd1000000, 30'd10000000, 30'd100000000, 30'd1000000000
    };

    typedef enum logic [1:0] {
        K_NUM = 2'd0,
        K_NAN = 2'd1,
        K_INF = 2'd2,
        K_OOR = 2'd3
    } kind_t;

    // scaled total and integer product, ready for the fraction split
    typedef struct packed {
        kind_t            kind;
        logic [3:0]       prec;
        logic [SCL_W-1:0] scale;
        logic [TOT_W-1:0] total;
        logic [TOT_W-1:0] sint;
        logic [IPR_W-1:0] ipart;
    } raw_t;

    // integer part, fraction part and digit count for the emitter
    typedef struct packed {
        kind_t            kind;
        logic [3:0]       prec;
        logic [INT_W-1:0] ipart;
        logic [SCL_W-1:0] fpart;
        logic [3:0]       ndig;
    } dec_t;

    // letters of "nan" and "inf", idx 2 is the first letter
    function automatic logic [7:0] text_char(kind_t kind, logic [1:0] idx);
        logic [7:0] ch;
        ch = CH_NUL;
        if (kind == K_NAN)
        begin
            case (idx)
                2'd2:    ch = 8'h6E;
                2'd1:    ch = 8'h61;
                default: ch = 8'h6E;
            endcase
        end
        else
        begin
            case (idx)
                2'd2:    ch = 8'h69;
                2'd1:    ch = 8'h6E;
                default: ch = 8'h66;
            endcase
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

[rtl/f2d_in_if.sv]
// input channel: float pattern and precision
`default_nettype none
interface f2d_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] float_bits;
    logic [3:0]  precision;

    modport source (output valid, output float_bits, output precision, input ready);
    modport sink (input valid, input float_bits, input precision, output ready);
endinterface
`default_nettype wire

[rtl/f2d_out_if.sv]
// output channel: one text character per beat
`default_nettype none
interface f2d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;
    logic       status;

    modport source (output valid, output char_code, output last, output status, input ready);
    modport sink (input valid, input char_code, input last, input status, output ready);
endinterface
`default_nettype wire

[rtl/f2d_scale.sv]
// decode, significand times power of ten, shift with round half to even
`default_nettype none
module f2d_scale (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [31:0]   float_bits,
    input  wire logic [3:0]    precision,
    output logic               o_valid,
    input  wire logic          o_ready,
    output f2d_pkg::raw_t      o_data
);

    typedef struct packed {
        f2d_pkg::kind_t                kind;
        logic [3:0]                    prec;
        logic [f2d_pkg::SIG_W-1:0]     sig;
        logic                          right;
        logic [f2d_pkg::SH_W-1:0]      sh;
        logic [f2d_pkg::SCL_W-1:0]     scale;
    } sa_t;

    typedef struct packed {
        f2d_pkg::kind_t                kind;
        logic [3:0]                    prec;
        logic [f2d_pkg::NUM_W-1:0]     numer;
        logic [f2d_pkg::IPR_W-1:0]     ipart;
        logic                          right;
        logic [f2d_pkg::SH_W-1:0]      sh;
        logic [f2d_pkg::SCL_W-1:0]     scale;
    } sb_t;

    logic a_v_reg, b_v_reg, c_v_reg;
    sa_t  sa_reg, sa_next;
    sb_t  sb_reg, sb_next;
    f2d_pkg::raw_t sc_reg, sc_next;
    logic a_ready, b_ready, c_ready;

    logic [7:0]                expb;
    logic [22:0]               frac;
    logic [f2d_pkg::SH_W-1:0]  sm1;
    logic [f2d_pkg::NUM_W-1:0] q;
    logic [f2d_pkg::NUM_W-1:0] mask;
    logic                      guard, sticky, rup;

    // stall chain: a stage moves when it is empty or the next one moves
    assign c_ready  = !c_v_reg || o_ready;
    assign b_ready  = !b_v_reg || c_ready;
    assign a_ready  = !a_v_reg || b_ready;
    assign in_ready = a_ready;
    assign o_valid  = c_v_reg;
    assign o_data   = sc_reg;

    // stage a: classify and unpack
    always_comb
    begin
        expb = float_bits[30:23];
        frac = float_bits[22:0];
        sa_next.prec  = (precision > 4'(f2d_pkg::MAX_PREC)) ? 4'(f2d_pkg::MAX_PREC) : precision;
        sa_next.scale = f2d_pkg::POW10[sa_next.prec];
        if (expb == f2d_pkg::EXP_SPECIAL)
            sa_next.kind = (frac != 23'd0) ? f2d_pkg::K_NAN : f2d_pkg::K_INF;
        else if (expb >= f2d_pkg::EXP_LIMIT)
            sa_next.kind = f2d_pkg::K_OOR;
        else
            sa_next.kind = f2d_pkg::K_NUM;
        sa_next.sig = (expb == 8'd0) ? {1'b0, frac} : {1'b1, frac};
        if (expb == 8'd0)
        begin
            sa_next.right = 1'b1;
            sa_next.sh    = f2d_pkg::SUB_SHIFT;
        end
        else if (expb >= f2d_pkg::EXP_UNIT)
        begin
            sa_next.right = 1'b0;
            sa_next.sh    = expb - f2d_pkg::EXP_UNIT;
        end
        else
        begin
            sa_next.right = 1'b1;
            sa_next.sh    = f2d_pkg::EXP_UNIT - expb;
        end
    end

    // stage b: product and truncated integer part
    always_comb
    begin
        sb_next.kind  = sa_reg.kind;
        sb_next.prec  = sa_reg.prec;
        sb_next.scale = sa_reg.scale;
        sb_next.right = sa_reg.right;
        sb_next.sh    = sa_reg.sh;
        sb_next.numer = f2d_pkg::NUM_W'(sa_reg.sig) * f2d_pkg::NUM_W'(sa_reg.scale);
        if (sa_reg.right)
            sb_next.ipart = f2d_pkg::IPR_W'(sa_reg.sig) >> sa_reg.sh;
        else
            sb_next.ipart = f2d_pkg::IPR_W'(sa_reg.sig) << sa_reg.sh;
    end

    // stage c: rounded scaled total and integer part times scale
    always_comb
    begin
        sm1    = sb_reg.sh - 8'd1;
        q      = sb_reg.numer >> sb_reg.sh;
        guard  = |((sb_reg.numer >> sm1) & f2d_pkg::NUM_W'(1));
        mask   = ~({f2d_pkg::NUM_W{1'b1}} << sm1);
        sticky = |(sb_reg.numer & mask);
        rup    = guard && (sticky || q[0]);
        sc_next.kind  = sb_reg.kind;
        sc_next.prec  = sb_reg.prec;
        sc_next.scale = sb_reg.scale;
        sc_next.ipart = sb_reg.ipart;
        if (sb_reg.right)
            sc_next.total = f2d_pkg::TOT_W'(q) + f2d_pkg::TOT_W'(rup);
        else
            sc_next.total = f2d_pkg::TOT_W'(sb_reg.numer) << sb_reg.sh;
        sc_next.sint = f2d_pkg::TOT_W'(sb_reg.ipart) * f2d_pkg::TOT_W'(sb_reg.scale);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_v_reg <= in_valid;
            if (b_ready)
                b_v_reg <= a_v_reg;
            if (c_ready)
                c_v_reg <= b_v_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
            sa_reg <= sa_next;
        if (b_ready && a_v_reg)
            sb_reg <= sb_next;
        if (c_ready && b_v_reg)
            sc_reg <= sc_next;
    end

endmodule
`default_nettype wire

[rtl/f2d_fract.sv]
// fraction split with carry, then integer digit count
`default_nettype none
module f2d_fract (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          i_valid,
    output logic               i_ready,
    input  f2d_pkg::raw_t      i_data,
    output logic               o_valid,
    input  wire logic          o_ready,
    output f2d_pkg::dec_t      o_data
);

    logic d_v_reg, e_v_reg;
    f2d_pkg::dec_t sd_reg, sd_next, se_reg, se_next;
    logic d_ready, e_ready;
    logic [f2d_pkg::TOT_W:0] d1, d2;
    logic [3:0] cnt;

    assign e_ready = !e_v_reg || o_ready;
    assign d_ready = !d_v_reg || e_ready;
    assign i_ready = d_ready;
    assign o_valid = e_v_reg;
    assign o_data  = se_reg;

    // stage d: total minus integer part times scale, carry into integer part
    always_comb
    begin
        d1 = {1'b0, i_data.total} - {1'b0, i_data.sint};
        d2 = d1 - (f2d_pkg::TOT_W + 1)'(i_data.scale);
        sd_next.kind = i_data.kind;
        sd_next.prec = i_data.prec;
        sd_next.ndig = 4'd1;
        if (d1[f2d_pkg::TOT_W])
        begin
            sd_next.fpart = '0;
            sd_next.ipart = f2d_pkg::INT_W'(i_data.ipart);
        end
        else if (!d2[f2d_pkg::TOT_W])
        begin
            sd_next.fpart = d2[f2d_pkg::SCL_W-1:0];
            sd_next.ipart = f2d_pkg::INT_W'(i_data.ipart) + f2d_pkg::INT_W'(1);
        end
        else
        begin
            sd_next.fpart = d1[f2d_pkg::SCL_W-1:0];
            sd_next.ipart = f2d_pkg::INT_W'(i_data.ipart);
        end
    end

    // stage e: number of integer digits
    always_comb
    begin
        cnt = 4'd1;
        for (int k = 1; k < 10; k++)
        begin
            if (sd_reg.ipart >= f2d_pkg::INT_W'(f2d_pkg::POW10[k]))
                cnt = cnt + 4'd1;
        end
        se_next      = sd_reg;
        se_next.ndig = cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end
        else
        begin
            if (d_ready)
                d_v_reg <= i_valid;
            if (e_ready)
                e_v_reg <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && i_valid)
            sd_reg <= sd_next;
        if (e_ready && d_v_reg)
            se_reg <= se_next;
    end

endmodule
`default_nettype wire

[rtl/f2d_emit.sv]
// character sequencer: one digit per beat, most significant first
`default_nettype none
module f2d_emit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          i_valid,
    output logic               i_ready,
    input  f2d_pkg::dec_t      i_data,
    output logic               o_valid,
    input  wire logic          o_ready,
    output logic [7:0]         o_char,
    output logic               o_last,
    output logic               o_status
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_INT, ST_DOT, ST_FRAC, ST_TEXT, ST_OOR
    } state_t;

    state_t state_reg, state_next;
    f2d_pkg::kind_t kind_reg;
    logic [3:0] prec_reg, k_reg, k_next;
    logic [f2d_pkg::INT_W-1:0] rem_reg, rem_next;
    logic [f2d_pkg::SCL_W-1:0] fpart_reg;
    logic valid_reg, valid_next, last_reg, last_next, status_reg, status_next;
    logic [7:0] char_reg, char_next;
    logic go;

    logic [f2d_pkg::DIG_W-1:0] p, sub;
    logic [f2d_pkg::DIG_W-1:0] prod [1:9];
    logic [3:0] digit;

    assign go       = !valid_reg || o_ready;
    assign i_ready  = (state_reg == ST_IDLE) && go;
    assign o_valid  = valid_reg;
    assign o_char   = char_reg;
    assign o_last   = last_reg;
    assign o_status = status_reg;

    // current decimal digit of the remainder at weight 10^k
    always_comb
    begin
        p     = f2d_pkg::DIG_W'(f2d_pkg::POW10[k_reg]);
        digit = 4'd0;
        sub   = '0;
        for (int m = 1; m < 10; m++)
        begin
            prod[m] = p * f2d_pkg::DIG_W'(m);
            if (f2d_pkg::DIG_W'(rem_reg) >= prod[m])
            begin
                digit = 4'(m);
                sub   = prod[m];
            end
        end
        rem_next = f2d_pkg::INT_W'(f2d_pkg::DIG_W'(rem_reg) - sub);
    end

    // sequencer next state and next beat
    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        valid_next  = valid_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        status_next = status_reg;
        if (go)
        begin
            valid_next  = state_reg != ST_IDLE;
            last_next   = 1'b0;
            status_next = 1'b0;
            char_next   = f2d_pkg::CH_ZERO + {4'd0, digit};
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (i_valid)
                    begin
                        unique case (i_data.kind)
                            f2d_pkg::K_NUM:
                            begin
                                state_next = ST_INT;
                                k_next     = i_data.ndig - 4'd1;
                            end
                            f2d_pkg::K_OOR: state_next = ST_OOR;
                            default:
                            begin
                                state_next = ST_TEXT;
                                k_next     = 4'd2;
                            end
                        endcase
                    end
                end
                ST_INT:
                begin
                    if (k_reg == 4'd0)
                    begin
                        last_next  = prec_reg == 4'd0;
                        state_next = (prec_reg == 4'd0) ? ST_IDLE : ST_DOT;
                    end
                    else
                        k_next = k_reg - 4'd1;
                end
                ST_DOT:
                begin
                    char_next  = f2d_pkg::CH_DOT;
                    k_next     = prec_reg - 4'd1;
                    state_next = ST_FRAC;
                end
                ST_FRAC:
                begin
                    if (k_reg == 4'd0)
                    begin
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                        k_next = k_reg - 4'd1;
                end
                ST_TEXT:
                begin
                    char_next = f2d_pkg::text_char(kind_reg, k_reg[1:0]);
                    if (k_reg == 4'd0)
                    begin
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                        k_next = k_reg - 4'd1;
                end
                ST_OOR:
                begin
                    char_next   = f2d_pkg::CH_NUL;
                    last_next   = 1'b1;
                    status_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    // state and output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            valid_reg  <= 1'b0;
            last_reg   <= 1'b0;
            status_reg <= 1'b0;
            char_reg   <= 8'd0;
            k_reg      <= 4'd0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            last_reg   <= last_next;
            status_reg <= status_next;
            char_reg   <= char_next;
            k_reg      <= k_next;
        end
    end

    // item payload and running remainder
    always_ff @(posedge clk)
    begin
        if (i_ready && i_valid)
        begin
            kind_reg  <= i_data.kind;
            prec_reg  <= i_data.prec;
            rem_reg   <= i_data.ipart;
            fpart_reg <= i_data.fpart;
        end
        else if (go && (state_reg == ST_INT || state_reg == ST_FRAC))
            rem_reg <= rem_next;
        else if (go && state_reg == ST_DOT)
            rem_reg <= f2d_pkg::INT_W'(fpart_reg);
    end

endmodule
`default_nettype wire

[rtl/float32_to_fixed_decimal_text_top.sv]
// top level: float32 to fixed-point decimal text
//
//  channel   dir  beat                           flow
//  in_ch     in   float_bits, precision          valid/ready
//  out_ch    out  char_code, last, status        valid/ready
//
// five register stages (decode, multiply, round, fraction split, digit count)
// then a sequencer that sends one character per cycle while out_ch is not
// stalled; it takes no new item until the last character of the current one
// is sent. the pipeline stages take a new item every cycle and stall in
// place when the sequencer is busy. reset clears all valid bits.
`default_nettype none
module float32_to_fixed_decimal_text_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    f2d_in_if.sink     in_ch,
    f2d_out_if.source  out_ch
);

    logic          raw_valid, raw_ready, dec_valid, dec_ready;
    f2d_pkg::raw_t raw_data;
    f2d_pkg::dec_t dec_data;

    f2d_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .float_bits (in_ch.float_bits),
        .precision  (in_ch.precision),
        .o_valid    (raw_valid),
        .o_ready    (raw_ready),
        .o_data     (raw_data)
    );

    f2d_fract u_fract (
        .clk     (clk),
        .rst_n   (rst_n),
        .i_valid (raw_valid),
        .i_ready (raw_ready),
        .i_data  (raw_data),
        .o_valid (dec_valid),
        .o_ready (dec_ready),
        .o_data  (dec_data)
    );

    f2d_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .i_valid  (dec_valid),
        .i_ready  (dec_ready),
        .i_data   (dec_data),
        .o_valid  (out_ch.valid),
        .o_ready  (out_ch.ready),
        .o_char   (out_ch.char_code),
        .o_last   (out_ch.last),
        .o_status (out_ch.status)
    );

endmodule
`default_nettype wire

[rtl/f2d_checker.sv]
// port checker for the float to decimal text block, bound to the top level
`default_nettype none
module f2d_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] char_code,
    input wire logic       last,
    input wire logic       status
);

    // a stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last)
            && $stable(status))
        else $error("stalled output beat changed");

    // out of range is a single nul beat
    a_oor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> last && char_code == 8'h00)
        else $error("out of range beat malformed");

    // a point never ends the text
    a_dot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_code == 8'h2E |-> !last && !status)
        else $error("text ends in a point");

    // ok beats carry only text characters
    a_chars: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status |-> (char_code >= 8'h30 && char_code <= 8'h39)
            || char_code == 8'h2E || char_code == 8'h6E || char_code == 8'h61
            || char_code == 8'h69 || char_code == 8'h66)
        else $error("unexpected character");

endmodule

bind float32_to_fixed_decimal_text_top f2d_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .char_code (out_ch.char_code),
    .last      (out_ch.last),
    .status    (out_ch.status)
);
`default_nettype wire
